FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, command and character codes, cell layout and the types
// passed between the console control logic and the cell store.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Fixed widths of the channel fields.
  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int INDEX_W   = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  // Default screen geometry.
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // Attribute used for the blanking pass after reset.
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_PUT,
    S_READ,
    S_FINISH
  } state_t;

  // One screen cell: character byte and attribute byte.
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
  } cell_t;

  // Request to start a whole-store sweep (clear or scroll up one row).
  typedef struct packed {
    logic               go;
    logic               scroll;
    logic [COLOR_W-1:0] color;
  } sweep_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_cmd_if.sv
// ----------------------------------------------------------------------------
// Text console command channel
// Valid/ready channel carrying one console command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_cmd_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [CHAR_W-1:0]  character;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, output cmd, output character, output cell_index,
                  input ready);
  modport sink   (input valid, input cmd, input character, input cell_index,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tcw_res_if.sv
// ----------------------------------------------------------------------------
// Text console result channel
// Valid/ready channel carrying one result item per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_res_if;
  import tcw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    cell_char;
  logic [COLOR_W-1:0]   cell_color;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_col;

  modport source (output valid, output cell_char, output cell_color,
                  output cursor_row, output cursor_col, input ready);
  modport sink   (input valid, input cell_char, input cell_color,
                  input cursor_row, input cursor_col, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// Text console writer core
// Character console engine: keeps a ROWS by COLUMNS screen of cells and a
// cursor, and executes put character, clear screen and read cell commands.
//
// Usage. Command items arrive on cmd_ch (valid/ready); every accepted item
// produces exactly one result item on res_ch, carrying the read cell (zero
// for commands other than read) and the cursor after the command. The user
// must write the text attribute through cfg_wr_en/cfg_wr_data only while the
// core is idle; the core itself has no check for this.
//
// Command handling. For a printable character, newline below the last row,
// backspace or unused command, any cell write and the result register load
// happen at the edge that accepts the item. A read passes the registered read
// port of the screen memory and the S_READ state, which loads the result.
// A clear, or a newline or wrap on the last row, runs a sweep through the
// memory one cell per cycle, after which S_FINISH or S_PUT loads the result.
// Reset. After rst the memory is blanked to spaces in attribute 15 by the
// same sweep, during which no item is accepted.
// Stalls. A finished result waits in the output register; the next item is
// taken in the same cycle as the result is taken, so the receiver sets pace.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_wr_en,
  input  wire [tcw_pkg::COLOR_W-1:0]  cfg_wr_data,
  tcw_cmd_if.sink                     cmd_ch,
  tcw_res_if.source                   res_ch
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);

  typedef logic [AW-1:0] addr_t;
  typedef logic [RW-1:0] row_t;
  typedef logic [CW-1:0] col_t;

  // Control state.
  state_t state;
  state_t state_next;
  row_t   cur_row;
  row_t   cur_row_next;
  col_t   cur_col;
  col_t   cur_col_next;
  logic   pend_put;
  logic   pend_put_next;
  logic   out_valid;

  // Text attribute register.
  logic [COLOR_W-1:0] text_color;

  // Payload registers.
  logic [CHAR_W-1:0]    put_char;
  logic [CHAR_W-1:0]    put_char_next;
  logic                 read_ok;
  logic [CHAR_W-1:0]    out_char;
  logic [COLOR_W-1:0]   out_color;
  logic [ROW_OUT_W-1:0] out_row;
  logic [COL_OUT_W-1:0] out_col;

  // Decoded command and cursor arithmetic.
  logic  accept;
  cmd_t  cmd;
  logic  is_newline;
  logic  is_backspace;
  logic  last_row;
  logic  wrap_pending;
  logic  read_in_range;
  row_t  bs_row;
  col_t  bs_col;
  addr_t here_addr;
  addr_t below_addr;
  addr_t bs_addr;
  addr_t last_row_addr;

  // Store interface.
  sweep_req_t           sweep;
  logic                 wr_en;
  addr_t                wr_addr;
  cell_t                wr_data;
  addr_t                rd_addr;
  cell_t                rd_data;
  logic                 busy;
  logic                 load_out;
  logic [CHAR_W-1:0]    res_char;
  logic [COLOR_W-1:0]   res_color;

  tcw_store #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .sweep   (sweep),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy)
  );

  // An item is taken only when no sweep runs and the result register is
  // free or is being emptied in this cycle.
  assign cmd_ch.ready = (state == S_IDLE) && !busy && (!out_valid || res_ch.ready);
  assign accept       = cmd_ch.valid && cmd_ch.ready;

  assign cmd           = cmd_t'(cmd_ch.cmd);
  assign is_newline    = (cmd_ch.character == CH_NEWLINE);
  assign is_backspace  = (cmd_ch.character == CH_BACKSPACE);
  assign last_row      = (cur_row == row_t'(ROWS - 1));
  assign wrap_pending  = (cur_col == col_t'(COLUMNS));
  assign read_in_range = (32'(cmd_ch.cell_index) < CELLS);

  // Backspace steps back across a row boundary, but not past home.
  always_comb begin
    bs_row = cur_row;
    bs_col = cur_col;
    if (cur_col == '0) begin
      if (cur_row != '0) begin
        bs_row = cur_row - 1'b1;
        bs_col = col_t'(COLUMNS - 1);
      end
    end else begin
      bs_col = cur_col - 1'b1;
    end
  end

  assign here_addr     = addr_t'(32'(cur_row) * COLUMNS + 32'(cur_col));
  assign below_addr    = addr_t'((32'(cur_row) + 1) * COLUMNS);
  assign bs_addr       = addr_t'(32'(bs_row) * COLUMNS + 32'(bs_col));
  assign last_row_addr = addr_t'((ROWS - 1) * COLUMNS);
  assign rd_addr       = addr_t'(32'(cmd_ch.cell_index));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUT: begin
              if (is_newline) begin
                if (last_row) begin
                  state_next = S_SWEEP;
                end
              end else if (!is_backspace && wrap_pending && last_row) begin
                state_next = S_SWEEP;
              end
            end
            CMD_CLEAR: state_next = S_SWEEP;
            CMD_READ:  state_next = S_READ;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        if (!busy) begin
          state_next = pend_put ? S_PUT : S_FINISH;
        end
      end
      S_PUT:    state_next = S_IDLE;
      S_READ:   state_next = S_IDLE;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: cursor update, store accesses, result load.
  always_comb begin
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    pend_put_next = pend_put;
    put_char_next = put_char;
    wr_en         = 1'b0;
    wr_addr       = here_addr;
    wr_data       = cell_t'{ch: cmd_ch.character, color: text_color};
    sweep         = '{go: 1'b0, scroll: 1'b0, color: text_color};
    load_out      = 1'b0;
    res_char      = '0;
    res_color     = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUT: begin
              if (is_newline) begin
                cur_col_next = '0;
                if (last_row) begin
                  sweep.go     = 1'b1;
                  sweep.scroll = 1'b1;
                end else begin
                  cur_row_next = cur_row + 1'b1;
                  load_out     = 1'b1;
                end
              end else if (is_backspace) begin
                cur_row_next = bs_row;
                cur_col_next = bs_col;
                wr_en        = 1'b1;
                wr_addr      = bs_addr;
                wr_data      = cell_t'{ch: CH_SPACE, color: text_color};
                load_out     = 1'b1;
              end else if (!wrap_pending) begin
                wr_en        = 1'b1;
                cur_col_next = cur_col + 1'b1;
                load_out     = 1'b1;
              end else if (!last_row) begin
                // Lazy wrap into the next row, then write at its start.
                wr_en        = 1'b1;
                wr_addr      = below_addr;
                cur_row_next = cur_row + 1'b1;
                cur_col_next = col_t'(1);
                load_out     = 1'b1;
              end else begin
                // Lazy wrap on the last row: scroll first, write afterwards.
                cur_col_next  = '0;
                sweep.go      = 1'b1;
                sweep.scroll  = 1'b1;
                pend_put_next = 1'b1;
                put_char_next = cmd_ch.character;
              end
            end
            CMD_CLEAR: begin
              cur_row_next = '0;
              cur_col_next = '0;
              sweep.go     = 1'b1;
            end
            CMD_READ: begin
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_PUT: begin
        wr_en         = 1'b1;
        wr_addr       = last_row_addr;
        wr_data       = cell_t'{ch: put_char, color: text_color};
        cur_col_next  = col_t'(1);
        pend_put_next = 1'b0;
        load_out      = 1'b1;
      end
      S_READ: begin
        load_out = 1'b1;
        if (read_ok) begin
          res_char  = rd_data.ch;
          res_color = rd_data.color;
        end
      end
      S_FINISH: begin
        load_out = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_row    <= '0;
      cur_col    <= '0;
      pend_put   <= 1'b0;
      out_valid  <= 1'b0;
      text_color <= RESET_COLOR;
    end else begin
      state    <= state_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      pend_put <= pend_put_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        text_color <= cfg_wr_data;
      end
    end
  end

  // Result payload; the cursor fields are cut to their channel widths.
  always_ff @(posedge clk) begin
    put_char <= put_char_next;
    if (accept) begin
      read_ok <= read_in_range;
    end
    if (load_out) begin
      out_char  <= res_char;
      out_color <= res_color;
      out_row   <= ROW_OUT_W'(32'(cur_row_next));
      out_col   <= COL_OUT_W'(32'(cur_col_next));
    end
  end

  assign res_ch.valid      = out_valid;
  assign res_ch.cell_char  = out_char;
  assign res_ch.cell_color = out_color;
  assign res_ch.cursor_row = out_row;
  assign res_ch.cursor_col = out_col;

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_store.sv
// ----------------------------------------------------------------------------
// Text console cell store
// Screen memory with one write and one registered read port, plus a sweep
// engine that blanks the whole store or scrolls it up by one row.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_store #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
  localparam int CELLS  = ROWS * COLUMNS,
  localparam int AW     = $clog2(CELLS)
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire tcw_pkg::sweep_req_t sweep,
  input  wire                     wr_en,
  input  wire [AW-1:0]            wr_addr,
  input  wire tcw_pkg::cell_t     wr_data,
  input  wire [AW-1:0]            rd_addr,
  output tcw_pkg::cell_t          rd_data,
  output logic                    busy
);
  import tcw_pkg::*;

  localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

  typedef logic [AW-1:0] addr_t;

  cell_t mem [CELLS];
  cell_t rd_q;

  logic               sw_active;
  addr_t              sw_idx;
  logic               sw_scroll;
  logic [COLOR_W-1:0] sw_color;
  logic               sw_copy;
  logic               s1_valid;
  addr_t              s1_addr;
  logic               s1_copy;

  logic  mem_we;
  addr_t mem_waddr;
  cell_t mem_wdata;
  addr_t mem_raddr;

  // During a scroll, cell i takes the content of cell i + COLUMNS; each read
  // happens in the cycle before its write and always above it, so no entry is
  // read after it has been overwritten in the same pass.
  assign sw_copy = sw_scroll && (32'(sw_idx) < SCROLL_CELLS);

  always_comb begin
    mem_raddr = rd_addr;
    if (sw_active) begin
      mem_raddr = sw_copy ? addr_t'(32'(sw_idx) + COLUMNS) : sw_idx;
    end
  end

  always_comb begin
    mem_we    = wr_en;
    mem_waddr = wr_addr;
    mem_wdata = wr_data;
    if (s1_valid) begin
      mem_we    = 1'b1;
      mem_waddr = s1_addr;
      mem_wdata = s1_copy ? rd_q : cell_t'{ch: CH_SPACE, color: sw_color};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_active <= 1'b1;
      sw_idx    <= '0;
      sw_scroll <= 1'b0;
      sw_color  <= RESET_COLOR;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= sw_active;
      s1_addr  <= sw_idx;
      s1_copy  <= sw_copy;
      if (sweep.go) begin
        sw_active <= 1'b1;
        sw_idx    <= '0;
        sw_scroll <= sweep.scroll;
        sw_color  <= sweep.color;
      end else if (sw_active) begin
        if (sw_idx == addr_t'(CELLS - 1)) begin
          sw_active <= 1'b0;
        end else begin
          sw_idx <= sw_idx + 1'b1;
        end
      end
    end
  end

  assign rd_data = rd_q;
  assign busy    = sw_active || s1_valid;

endmodule

`default_nettype wire

FILE: bench/text_console_writer_core_test.sv
// ----------------------------------------------------------------------------
// Text console writer core testbench
// Drives command items into the console core and checks every result item
// against a cycle-free software mirror of the screen store and cursor. A short
// directed opening covers the corner cases, and random phases follow. Each
// phase runs under its own text attribute. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS  = COLUMNS_DEFAULT;
  localparam int LINES = ROWS_DEFAULT;
  localparam int CELLS = COLS * LINES;

  // The channel carries two command bits, so the fourth code exists on the
  // wire even though the core gives it no meaning.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // A clear or a scroll sweeps the whole store, and the long receiver hold-off
  // may come on top, so the quiet-cycle limit leaves a wide margin over both.
  localparam int QUIET_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 220;

  // One result item as the core reports it.
  typedef struct packed {
    logic [CHAR_W-1:0]    cell_char;
    logic [COLOR_W-1:0]   cell_color;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
  } console_report_t;

  // Mirror of the console: screen cells, cursor and attribute register, plus
  // the queue of reports that the accepted commands are still owed.
  class console_scoreboard;
    logic [CHAR_W-1:0]  glyph [CELLS];
    logic [COLOR_W-1:0] attr  [CELLS];
    int unsigned        row;
    int unsigned        col;
    logic [COLOR_W-1:0] colour;
    console_report_t    awaited_reports [$];
    int                 failures;

    function new();
      colour   = RESET_COLOR;
      failures = 0;
      mirror_clear();
    endfunction

    function void set_colour(logic [COLOR_W-1:0] value);
      colour = value;
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction

    function void mirror_blank(int unsigned idx);
      if (idx < CELLS) begin
        glyph[idx] = CH_SPACE;
        attr[idx]  = colour;
      end
    endfunction

    function void mirror_clear();
      for (int i = 0; i < CELLS; i++) mirror_blank(i);
      row = 0;
      col = 0;
    endfunction

    // Newline: next row, or scroll everything up one row on the last one.
    function void mirror_newline();
      col = 0;
      if (row < LINES - 1) begin
        row++;
      end else begin
        for (int i = 0; i < CELLS - COLS; i++) begin
          glyph[i] = glyph[i + COLS];
          attr[i]  = attr[i + COLS];
        end
        for (int c = 0; c < COLS; c++) mirror_blank((LINES - 1) * COLS + c);
      end
    endfunction

    function void mirror_put(logic [CHAR_W-1:0] ch);
      int unsigned idx;
      if (ch == CH_NEWLINE) begin
        mirror_newline();
        return;
      end
      if (ch == CH_BACKSPACE) begin
        if (col == 0 && row > 0) begin
          row--;
          col = COLS - 1;
        end else if (col > 0) begin
          col--;
        end
        mirror_blank(row * COLS + col);
        return;
      end
      // A column equal to the width means a wrap is pending.
      if (col >= COLS) mirror_newline();
      idx = row * COLS + col;
      if (idx < CELLS) begin
        glyph[idx] = ch;
        attr[idx]  = colour;
      end
      col++;
    endfunction

    function void note_command(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                               logic [INDEX_W-1:0] idx);
      console_report_t r;
      r = '0;
      case (op)
        CMD_PUT:   mirror_put(ch);
        CMD_CLEAR: mirror_clear();
        CMD_READ: begin
          if (idx < CELLS) begin
            r.cell_char  = glyph[idx];
            r.cell_color = attr[idx];
          end
        end
        default: ;
      endcase
      r.cursor_row = row[ROW_OUT_W-1:0];
      r.cursor_col = col[COL_OUT_W-1:0];
      awaited_reports.push_back(r);
    endfunction

    function void check_result(console_report_t got);
      console_report_t want;
      if (awaited_reports.size() == 0) begin
        $error("result item arrived with no command outstanding");
        failures++;
        return;
      end
      want = awaited_reports.pop_front();
      if (got.cell_char !== want.cell_char) begin
        $error("cell_char: expected %0d, got %0d", want.cell_char, got.cell_char);
        failures++;
      end
      if (got.cell_color !== want.cell_color) begin
        $error("cell_color: expected %0d, got %0d", want.cell_color, got.cell_color);
        failures++;
      end
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
        failures++;
      end
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
        failures++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [COLOR_W-1:0] cfg_wr_data;

  tcw_cmd_if cmd_ch ();
  tcw_res_if res_ch ();

  text_console_writer_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd_ch     (cmd_ch),
    .res_ch     (res_ch)
  );

  console_scoreboard sb = new();

  int commands_issued = 0;
  int results_seen    = 0;
  int quiet_cycles    = 0;
  bit no_idle         = 1'b0;

  // Clock, and a reset held at the very start of the run.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Gap lengths: mostly none, else from one of three ranges, the longer ones rarer.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one command item and hold it until the core takes it. Valid stays
  // high between back-to-back items, so it is only lowered when a gap is due.
  task automatic issue_command(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                               logic [INDEX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= op;
    cmd_ch.character  <= ch;
    cmd_ch.cell_index <= idx;
    do @(posedge clk); while (!cmd_ch.ready);
    commands_issued++;
  endtask

  // A put carries a random cell index, which the core ignores, so that the
  // index bits keep toggling on every kind of item.
  task automatic put_char(logic [CHAR_W-1:0] ch);
    issue_command(CMD_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
  endtask

  // Stop offering and wait for every owed result item to come back. The
  // first edge lets the monitor note an item taken at the current edge.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Random traffic built from short sequences. Text bursts, newlines and
  // backspaces keep the cursor moving over the whole screen; full lines set up
  // a pending wrap; clears are rare because each costs a whole sweep.
  task automatic random_traffic(int target);
    int kind;
    int n;
    logic [CHAR_W-1:0] b;
    while (commands_issued < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = $urandom_range(1, 30);
        repeat (n) put_char(CHAR_W'($urandom_range(0, 255)));
      end else if (kind < 60) begin
        put_char(CH_NEWLINE);
      end else if (kind < 70) begin
        n = $urandom_range(1, 5);
        repeat (n) put_char(CH_BACKSPACE);
      end else if (kind < 84) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          issue_command(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                        INDEX_W'($urandom_range(0, ($urandom_range(0, 3) == 0) ?
                                                      2047 : CELLS - 1)));
        end
      end else if (kind < 88) begin
        // A newline and then exactly one line of text leaves a wrap pending;
        // what follows takes the wrap, backs out of it, starts a new line or reads a cell.
        put_char(CH_NEWLINE);
        repeat (COLS) begin
          b = CHAR_W'($urandom_range(0, 255));
          if (b == CH_NEWLINE || b == CH_BACKSPACE) b = 8'h2A;
          put_char(b);
        end
        case ($urandom_range(0, 3))
          0: put_char(CH_BACKSPACE);
          1: put_char(8'h23);
          2: put_char(CH_NEWLINE);
          default: issue_command(CMD_READ, 8'h00,
                                 INDEX_W'($urandom_range(0, CELLS - 1)));
        endcase
      end else if (kind < 90) begin
        issue_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 2047)));
        if ($urandom_range(0, 1) == 1) put_char(CH_BACKSPACE);
      end else if (kind < 95) begin
        issue_command(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 2047)));
      end else begin
        // Noise: any command with any fields.
        issue_command(CMD_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 2047)));
      end
    end
  endtask

  // Command side: directed opening, then the random phases, then the verdict.
  initial begin : stimulus
    logic [COLOR_W-1:0] palette [PHASES];
    palette[0] = 8'h00;
    palette[1] = 8'hFF;
    palette[2] = COLOR_W'($urandom_range(0, 255));
    palette[3] = RESET_COLOR;
    palette[4] = COLOR_W'($urandom_range(0, 255));

    cmd_ch.valid      <= 1'b0;
    cmd_ch.cmd        <= CMD_PUT;
    cmd_ch.character  <= '0;
    cmd_ch.cell_index <= '0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    do @(posedge clk); while (rst);

    // The opening runs under the reset attribute. Reads of the blank store
    // at both ends, just past the end and at the highest index, then the
    // unused command with every field bit set.
    issue_command(CMD_READ, 8'h00, 11'd0);
    issue_command(CMD_READ, 8'hFF, 11'd1999);
    issue_command(CMD_READ, 8'h00, 11'd2000);
    issue_command(CMD_READ, 8'h00, 11'h7FF);
    issue_command(CMD_UNUSED, 8'hFF, 11'h7FF);
    // Backspace at home stays put and blanks the home cell.
    put_char(CH_BACKSPACE);
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(8'h55);
    put_char(8'hAA);
    issue_command(CMD_READ, 8'h00, 11'd0);
    issue_command(CMD_READ, 8'h00, 11'd4);
    put_char(CH_BACKSPACE);
    issue_command(CMD_READ, 8'h00, 11'd4);
    // Backspace at the start of a row goes back to the end of the row above.
    put_char(CH_NEWLINE);
    put_char(CH_BACKSPACE);
    // The last column leaves a wrap pending; a backspace then steps back
    // into the last column, and a later character takes the wrap.
    put_char(8'h5A);
    put_char(CH_BACKSPACE);
    put_char(8'h7E);
    put_char(8'h21);
    issue_command(CMD_READ, 8'h00, 11'd80);
    issue_command(CMD_CLEAR, 8'h00, 11'd0);
    issue_command(CMD_READ, 8'h00, 11'd80);

    // Each phase begins with the sender paused until every owed result has
    // come, so the attribute register is only written while the core is idle.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= palette[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      sb.set_colour(palette[p]);
      // One phase runs flat out on both sides.
      no_idle = (p == 3);
      random_traffic(commands_issued + PHASE_ITEMS);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("text_console_writer_core verification clean");
    end else begin
      $display("text_console_writer_core verification failed");
    end
    $finish;
  end

  // Result side. Ready mostly stays high with random stalls; once, well into
  // the run, it is held low for a long stretch so that the result register
  // fills and the core has to stall the command side.
  initial begin : receiver
    int hold;
    int run;
    bit long_done;
    long_done = 1'b0;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!long_done && results_seen >= 300) begin
        hold      = LONG_HOLD;
        long_done = 1'b1;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
    end
  end

  // Handshake monitors. Every accepted command item is fed to the mirror at
  // the edge that takes it, and every accepted result item is checked.
  always @(posedge clk) begin
    console_report_t got;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        sb.note_command(cmd_ch.cmd, cmd_ch.character, cmd_ch.cell_index);
      end
      if (res_ch.valid && res_ch.ready) begin
        got.cell_char  = res_ch.cell_char;
        got.cell_color = res_ch.cell_color;
        got.cursor_row = res_ch.cursor_row;
        got.cursor_col = res_ch.cursor_col;
        results_seen++;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: too many cycles in a row with no item moving on either channel
  // means the core has hung.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("text_console_writer_core verification failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
